FILE: sv/cs_pkg.sv
// Shared constants, controller states and command/status types for cosine_similarity.
`timescale 1ns / 1ps

package cs_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int ELEM_BITS    = 16;
	localparam int SQ_BITS      = 2 * ELEM_BITS - 1;
	localparam int PROD_BITS    = 2 * ELEM_BITS;
	localparam int NORM_BITS    = SQ_BITS + $clog2(MAX_ELEMENTS);
	localparam int DOT_BITS     = NORM_BITS + 1;
	localparam int EPS_SHIFT    = 20;
	localparam int SQ_IN_BITS   = NORM_BITS + 1 + EPS_SHIFT;
	localparam int ROOT_BITS    = SQ_IN_BITS / 2;
	localparam int REM_BITS     = ROOT_BITS + 2;
	localparam int PRODP_BITS   = 2 * ROOT_BITS;
	localparam int FRAC_OUT     = 15;
	localparam int OUT_BITS     = FRAC_OUT + 1;
	localparam int CNT_BITS     = $clog2(ROOT_BITS);

	typedef enum logic [3:0] {
		S_ACC,
		S_DRAIN,
		S_LDA,
		S_SQA,
		S_LDB,
		S_SQB,
		S_MUL,
		S_CMP,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_a;
		logic load_b;
		logic sq_step;
		logic mul;
		logic cmp;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sq_done;
		logic div_done;
	} status_t;

endpackage

FILE: sv/cosine_similarity.sv
// Top level of the streaming cosine similarity block.
//
// Usage: element pairs (elem_a, elem_b, Q4.12) arrive on the in_valid/in_ready
// channel, one item per cycle while the block is accumulating. vector_missing
// on any item of a vector forces that vector's result to zero. The item with
// last set closes the vector and produces one item on out_valid/out_ready:
// similarity in Q1.15, saturated.
// Finish sequence: the shared one-bit-per-cycle square root, run twice (once
// per norm), and the restoring divider, plus load and setup steps.
// Throughput: one item per cycle inside a vector; in_ready is low during the
// finish sequence.
// While a result waits, non-last items of the next vector are still taken;
// a last item is held off until the pending result is taken.
// Reset (arst_n low) clears the sums, the controller and the output valid.
`timescale 1ns / 1ps

module cosine_similarity (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [cs_pkg::ELEM_BITS-1:0] elem_a,
	input  logic signed [cs_pkg::ELEM_BITS-1:0] elem_b,
	input  logic                                last,
	input  logic                                vector_missing,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cs_pkg::OUT_BITS-1:0]  similarity
);

	cs_pkg::cmd_t    cmd;
	cs_pkg::status_t status;

	cs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	cs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.elem_a         (elem_a),
		.elem_b         (elem_b),
		.vector_missing (vector_missing),
		.status         (status),
		.similarity     (similarity)
	);

endmodule

FILE: sv/cs_datapath.sv
// Datapath: product stage, saturating sums, shared square root, divider and result register.
`timescale 1ns / 1ps

module cs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cs_pkg::cmd_t                        cmd,
	input  logic signed [cs_pkg::ELEM_BITS-1:0] elem_a,
	input  logic signed [cs_pkg::ELEM_BITS-1:0] elem_b,
	input  logic                                vector_missing,
	output cs_pkg::status_t                     status,
	output logic signed [cs_pkg::OUT_BITS-1:0]  similarity
);

	localparam int DB = cs_pkg::DOT_BITS;
	localparam int NB = cs_pkg::NORM_BITS;
	localparam int RB = cs_pkg::ROOT_BITS;
	localparam int VB = cs_pkg::SQ_IN_BITS;
	localparam int MB = cs_pkg::REM_BITS;
	localparam int PB = cs_pkg::PRODP_BITS;
	localparam int QB = cs_pkg::FRAC_OUT;
	localparam int OB = cs_pkg::OUT_BITS;

	logic                                valid_s1;
	logic signed [cs_pkg::PROD_BITS-1:0] prod_ab_s1;
	logic [cs_pkg::SQ_BITS-1:0]          sq_a_s1;
	logic [cs_pkg::SQ_BITS-1:0]          sq_b_s1;
	logic                                miss_s1;

	logic signed [DB-1:0] dot_sum_q;
	logic [NB-1:0]        norm_a_sum_q;
	logic [NB-1:0]        norm_b_sum_q;
	logic                 missing_seen_q;

	logic [VB-1:0] sq_v_q;
	logic [MB-1:0] sq_rem_q;
	logic [RB-1:0] sq_root_q;
	logic [RB-1:0] sa_q;
	logic [cs_pkg::CNT_BITS-1:0] cnt_q;

	logic [PB-1:0] p_q;
	logic [PB-1:0] r_q;
	logic [QB-1:0] q_q;
	logic          neg_q;
	logic          sat_q;
	logic signed [OB-1:0] similarity_q;

	logic signed [cs_pkg::PROD_BITS-1:0] prod_ab;
	logic signed [cs_pkg::PROD_BITS-1:0] prod_aa;
	logic signed [cs_pkg::PROD_BITS-1:0] prod_bb;
	logic signed [DB:0]   dot_sum_wide;
	logic signed [DB-1:0] dot_next;
	logic [NB:0]          norm_a_wide;
	logic [NB:0]          norm_b_wide;
	logic [NB-1:0]        norm_a_next;
	logic [NB-1:0]        norm_b_next;
	logic [MB+1:0]        rem_sh;
	logic [MB+1:0]        trial;
	logic                 sq_fit;
	logic [PB:0]          r_sh;
	logic                 div_fit;
	logic [DB-1:0]        dot_mag;
	logic [VB-1:0]        norm_sel;
	logic signed [OB-1:0] q_signed;

	assign prod_ab = cs_pkg::PROD_BITS'(elem_a) * cs_pkg::PROD_BITS'(elem_b);
	assign prod_aa = cs_pkg::PROD_BITS'(elem_a) * cs_pkg::PROD_BITS'(elem_a);
	assign prod_bb = cs_pkg::PROD_BITS'(elem_b) * cs_pkg::PROD_BITS'(elem_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.capture;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_ab_s1 <= prod_ab;
			sq_a_s1    <= prod_aa[cs_pkg::SQ_BITS-1:0];
			sq_b_s1    <= prod_bb[cs_pkg::SQ_BITS-1:0];
			miss_s1    <= vector_missing;
		end
	end

	always_comb begin
		dot_sum_wide = {dot_sum_q[DB-1], dot_sum_q} + (DB + 1)'(prod_ab_s1);
		if (dot_sum_wide[DB] != dot_sum_wide[DB-1]) begin
			dot_next = dot_sum_wide[DB] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
		end else begin
			dot_next = dot_sum_wide[DB-1:0];
		end
		norm_a_wide = {1'b0, norm_a_sum_q} + (NB + 1)'(sq_a_s1);
		norm_b_wide = {1'b0, norm_b_sum_q} + (NB + 1)'(sq_b_s1);
		norm_a_next = norm_a_wide[NB] ? {NB{1'b1}} : norm_a_wide[NB-1:0];
		norm_b_next = norm_b_wide[NB] ? {NB{1'b1}} : norm_b_wide[NB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_sum_q      <= '0;
			norm_a_sum_q   <= '0;
			norm_b_sum_q   <= '0;
			missing_seen_q <= 1'b0;
		end else if (cmd.finish) begin
			dot_sum_q      <= '0;
			norm_a_sum_q   <= '0;
			norm_b_sum_q   <= '0;
			missing_seen_q <= 1'b0;
		end else if (valid_s1) begin
			dot_sum_q      <= dot_next;
			norm_a_sum_q   <= norm_a_next;
			norm_b_sum_q   <= norm_b_next;
			missing_seen_q <= missing_seen_q | miss_s1;
		end
	end

	always_comb begin
		norm_sel = {(cmd.load_a ? ({1'b0, norm_a_sum_q} + (NB + 1)'(1))
			: ({1'b0, norm_b_sum_q} + (NB + 1)'(1))), {cs_pkg::EPS_SHIFT{1'b0}}};
		rem_sh   = {sq_rem_q, sq_v_q[VB-1 -: 2]};
		trial    = {2'b00, sq_root_q, 2'b01};
		sq_fit   = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_a || cmd.load_b) begin
			sq_v_q    <= norm_sel;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (cmd.sq_step) begin
			sq_v_q <= {sq_v_q[VB-3:0], 2'b00};
			if (sq_fit) begin
				sq_rem_q  <= MB'(rem_sh - trial);
				sq_root_q <= {sq_root_q[RB-2:0], 1'b1};
			end else begin
				sq_rem_q  <= rem_sh[MB-1:0];
				sq_root_q <= {sq_root_q[RB-2:0], 1'b0};
			end
		end
		if (cmd.load_b) begin
			sa_q <= sq_root_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_a || cmd.load_b || cmd.mul) begin
			cnt_q <= '0;
		end else if (cmd.sq_step || cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign status.sq_done  = cnt_q == cs_pkg::CNT_BITS'(RB - 1);
	assign status.div_done = cnt_q == cs_pkg::CNT_BITS'(QB - 1);

	always_comb begin
		dot_mag  = dot_sum_q[DB-1] ? DB'(-dot_sum_q) : DB'(dot_sum_q);
		r_sh     = {r_q, 1'b0};
		div_fit  = r_sh >= {1'b0, p_q};
		q_signed = neg_q ? -OB'(q_q) : OB'(q_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_q   <= PB'(sa_q) * PB'(sq_root_q);
			r_q   <= PB'({dot_mag, {cs_pkg::EPS_SHIFT{1'b0}}});
			neg_q <= dot_sum_q[DB-1];
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (div_fit) begin
				r_q <= PB'(r_sh - {1'b0, p_q});
				q_q <= {q_q[QB-2:0], 1'b1};
			end else begin
				r_q <= r_sh[PB-1:0];
				q_q <= {q_q[QB-2:0], 1'b0};
			end
		end
		if (cmd.cmp) begin
			sat_q <= r_q >= p_q;
		end
		if (cmd.finish) begin
			if (missing_seen_q) begin
				similarity_q <= '0;
			end else if (sat_q) begin
				similarity_q <= neg_q ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
			end else begin
				similarity_q <= q_signed;
			end
		end
	end

	assign similarity = similarity_q;

endmodule

FILE: sv/cs_ctrl.sv
// Controller: accumulate/finish state machine driving the datapath commands and handshakes.
`timescale 1ns / 1ps

module cs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last,
	input  logic            out_ready,
	input  cs_pkg::status_t status,
	output logic            in_ready,
	output logic            out_valid,
	output cs_pkg::cmd_t    cmd
);

	cs_pkg::state_t state_q;
	cs_pkg::state_t state_d;
	logic           accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cs_pkg::S_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cs_pkg::S_ACC: begin
				if (accept && last) state_d = cs_pkg::S_DRAIN;
			end
			cs_pkg::S_DRAIN: state_d = cs_pkg::S_LDA;
			cs_pkg::S_LDA:   state_d = cs_pkg::S_SQA;
			cs_pkg::S_SQA: begin
				if (status.sq_done) state_d = cs_pkg::S_LDB;
			end
			cs_pkg::S_LDB:   state_d = cs_pkg::S_SQB;
			cs_pkg::S_SQB: begin
				if (status.sq_done) state_d = cs_pkg::S_MUL;
			end
			cs_pkg::S_MUL:   state_d = cs_pkg::S_CMP;
			cs_pkg::S_CMP:   state_d = cs_pkg::S_DIV;
			cs_pkg::S_DIV: begin
				if (status.div_done) state_d = cs_pkg::S_FIN;
			end
			cs_pkg::S_FIN:   state_d = cs_pkg::S_OUT;
			cs_pkg::S_OUT: begin
				if (accept && last) state_d = cs_pkg::S_DRAIN;
				else if (out_ready) state_d = cs_pkg::S_ACC;
			end
			default:         state_d = cs_pkg::S_ACC;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			cs_pkg::S_ACC: in_ready = 1'b1;
			cs_pkg::S_LDA: cmd.load_a = 1'b1;
			cs_pkg::S_SQA, cs_pkg::S_SQB: cmd.sq_step = 1'b1;
			cs_pkg::S_LDB: cmd.load_b = 1'b1;
			cs_pkg::S_MUL: cmd.mul = 1'b1;
			cs_pkg::S_CMP: cmd.cmp = 1'b1;
			cs_pkg::S_DIV: cmd.div_step = 1'b1;
			cs_pkg::S_FIN: cmd.finish = 1'b1;
			cs_pkg::S_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready || !last;
			end
			default: ;
		endcase
		cmd.capture = in_valid && in_ready;
	end

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> state_q == cs_pkg::S_DRAIN)
		else $error("last item did not start the finish sequence");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cs_pkg::S_ACC && state_q != cs_pkg::S_OUT) |-> !in_ready)
		else $error("item accepted while finishing");

	a_sqa_to_ldb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cs_pkg::S_SQA && status.sq_done |=> state_q == cs_pkg::S_LDB)
		else $error("square root of first norm did not hand over");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cmd.finish))
		else $error("pending result dropped");

endmodule

FILE: dv/tb_cosine_similarity.sv
// Self-checking testbench for cosine_similarity: directed, saturation and random vectors.
`timescale 1ns / 1ps

module tb_cosine_similarity;

	typedef logic signed [cs_pkg::ELEM_BITS-1:0] elem_t;
	typedef logic signed [cs_pkg::OUT_BITS-1:0]  sim_t;
	typedef bit [63:0]                           u64_t;

	localparam elem_t  ELEM_MAX   = {1'b0, {(cs_pkg::ELEM_BITS-1){1'b1}}};
	localparam elem_t  ELEM_MIN   = ~ELEM_MAX;
	localparam sim_t   SIM_MAX    = {1'b0, {(cs_pkg::OUT_BITS-1){1'b1}}};
	localparam sim_t   SIM_MIN    = ~SIM_MAX;
	localparam longint DOT_MAX    = (longint'(1) << (cs_pkg::DOT_BITS-1)) - 1;
	localparam longint DOT_MIN    = -DOT_MAX - 1;
	localparam longint NORM_MAX   = (longint'(1) << cs_pkg::NORM_BITS) - 1;
	localparam int     QUIET_MAX  = 1000;
	localparam int     SAT_LEN    = 100;
	localparam int     RAND_ITEMS = 630;

	logic  clk;
	logic  arst_n         = 1'b0;
	logic  in_valid       = 1'b0;
	logic  in_ready;
	elem_t elem_a         = '0;
	elem_t elem_b         = '0;
	logic  last           = 1'b0;
	logic  vector_missing = 1'b0;
	logic  out_valid;
	logic  out_ready      = 1'b0;
	sim_t  similarity;

	logic signed [cs_pkg::DOT_BITS-1:0] dot_acc    = '0;
	logic [cs_pkg::NORM_BITS-1:0]       norm_a_acc = '0;
	logic [cs_pkg::NORM_BITS-1:0]       norm_b_acc = '0;
	logic                               miss_flag  = 1'b0;

	sim_t sim_expected[$];
	int   err_count   = 0;
	int   gap_pct     = 12;
	int   quiet_count = 0;
	bit   in_taken    = 0;
	bit   out_taken   = 0;

	cosine_similarity dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.elem_a         (elem_a),
		.elem_b         (elem_b),
		.last           (last),
		.vector_missing (vector_missing),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.similarity     (similarity)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic u64_t int_sqrt(u64_t v);
		u64_t root;
		u64_t probe;
		root  = 0;
		probe = u64_t'(1) << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v   -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic sim_t cosine_q15();
		u64_t   den;
		u64_t   rem;
		u64_t   quo;
		longint d;
		bit     neg;
		den = int_sqrt((u64_t'(norm_a_acc) + 1) << cs_pkg::EPS_SHIFT) *
			int_sqrt((u64_t'(norm_b_acc) + 1) << cs_pkg::EPS_SHIFT);
		d   = dot_acc;
		neg = d < 0;
		rem = neg ? u64_t'(-d) : u64_t'(d);
		rem <<= cs_pkg::EPS_SHIFT;
		if (rem >= den)
			return neg ? SIM_MIN : SIM_MAX;
		quo = 0;
		for (int i = 0; i < cs_pkg::FRAC_OUT; i++) begin
			rem <<= 1;
			quo <<= 1;
			if (rem >= den) begin
				rem -= den;
				quo |= 1;
			end
		end
		return neg ? sim_t'(-quo) : sim_t'(quo);
	endfunction

	task automatic absorb_pair(input elem_t a, input elem_t b, input logic lst, input logic miss);
		longint s;
		longint na;
		longint nb;
		s  = longint'(dot_acc) + longint'(a) * longint'(b);
		na = longint'(norm_a_acc) + longint'(a) * longint'(a);
		nb = longint'(norm_b_acc) + longint'(b) * longint'(b);
		if (s > DOT_MAX)
			s = DOT_MAX;
		if (s < DOT_MIN)
			s = DOT_MIN;
		if (na > NORM_MAX)
			na = NORM_MAX;
		if (nb > NORM_MAX)
			nb = NORM_MAX;
		dot_acc    = s;
		norm_a_acc = na;
		norm_b_acc = nb;
		if (miss)
			miss_flag = 1'b1;
		if (lst) begin
			sim_expected.insert(sim_expected.size(), miss_flag ? sim_t'(0) : cosine_q15());
			dot_acc    = '0;
			norm_a_acc = '0;
			norm_b_acc = '0;
			miss_flag  = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input sim_t got, input sim_t want);
		$display("ERROR %0t: %s: similarity %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// hold the item until accepted, then advance the predictor
	task automatic send_pair(input elem_t a, input elem_t b, input logic lst, input logic miss);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		elem_a         <= a;
		elem_b         <= b;
		last           <= lst;
		vector_missing <= miss;
		do
			@(negedge clk);
		while (in_ready !== 1'b1);
		@(posedge clk);
		absorb_pair(a, b, lst, miss);
	endtask

	function automatic elem_t pick_elem();
		case ($urandom_range(9))
			0:       return ELEM_MAX;
			1:       return ELEM_MIN;
			2, 3:    return elem_t'(int'($urandom_range(255)) - 128);
			default: return elem_t'($urandom());
		endcase
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= gap_pct);

	always @(negedge clk) begin
		in_taken  = in_valid && (in_ready === 1'b1);
		out_taken = (out_valid === 1'b1) && out_ready;
		if (out_taken) begin
			if (sim_expected.size() == 0)
				report_mismatch("unexpected item", similarity, '0);
			else if (similarity !== sim_expected[0])
				report_mismatch("wrong value", similarity, sim_expected.pop_front());
			else
				void'(sim_expected.pop_front());
		end
	end

	always @(posedge clk) begin
		if (in_taken || out_taken)
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= QUIET_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_directed();
		send_pair(ELEM_MAX, ELEM_MAX, 1'b1, 1'b0);
		send_pair(ELEM_MIN, ELEM_MAX, 1'b1, 1'b0);
		send_pair(ELEM_MIN, ELEM_MIN, 1'b0, 1'b0);
		send_pair(0, 0, 1'b1, 1'b0);
		send_pair(0, 0, 1'b0, 1'b0);
		send_pair(0, 0, 1'b0, 1'b0);
		send_pair(0, 0, 1'b1, 1'b0);
		send_pair(100, 200, 1'b0, 1'b0);
		send_pair(300, -7, 1'b0, 1'b1);
		send_pair(5, 6, 1'b1, 1'b0);
		send_pair(ELEM_MAX, ELEM_MAX, 1'b0, 1'b0);
		send_pair(ELEM_MAX, ELEM_MAX, 1'b1, 1'b1);
		send_pair(ELEM_MAX, ELEM_MIN, 1'b0, 1'b0);
		send_pair(ELEM_MIN, ELEM_MAX, 1'b0, 1'b0);
		send_pair(1, -1, 1'b1, 1'b0);
		send_pair(1, 1, 1'b1, 1'b0);
		send_pair(-1, 1, 1'b1, 1'b0);
		send_pair(4096, 2048, 1'b0, 1'b0);
		send_pair(-4096, 2048, 1'b1, 1'b0);
	endtask

	task automatic test_saturation();
		for (int i = 0; i < SAT_LEN; i++)
			send_pair(ELEM_MIN, ELEM_MIN, i == SAT_LEN - 1, 1'b0);
		for (int i = 0; i < SAT_LEN; i++)
			send_pair(ELEM_MIN, ELEM_MAX, i == SAT_LEN - 1, 1'b0);
	endtask

	task automatic test_random();
		int    sent;
		int    len;
		int    mode;
		int    miss_at;
		int    k;
		int    noise;
		elem_t a;
		elem_t b;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			gap_pct = (sent >= 300 && sent < 500) ? 0 : 12;
			k       = $urandom_range(99);
			len     = (k < 70) ? $urandom_range(1, 8) :
				(k < 95) ? $urandom_range(9, 64) : $urandom_range(65, 300);
			mode    = $urandom_range(3);
			miss_at = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1;
			for (int i = 0; i < len; i++) begin
				a     = pick_elem();
				noise = int'($urandom_range(63)) - 32;
				case (mode)
					0:       b = pick_elem();
					1:       b = a;
					2:       b = -a;
					default: b = elem_t'(int'(a) + noise);
				endcase
				send_pair(a, b, i == len - 1, i == miss_at);
			end
			sent += len;
		end
		gap_pct = 12;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_random();
		in_valid <= 1'b0;
		while (sim_expected.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: cosine_similarity.f
sv/cs_pkg.sv
sv/cs_datapath.sv
sv/cs_ctrl.sv
sv/cosine_similarity.sv
dv/tb_cosine_similarity.sv
